[design/lcdn_pkg.sv]
package lcdn_pkg;

    // request kinds
    localparam logic [1:0] REQ_CHAR   = 2'd0;
    localparam logic [1:0] REQ_CMD    = 2'd1;
    localparam logic [1:0] REQ_CURSOR = 2'd2;
    localparam logic [1:0] REQ_INIT   = 2'd3;

    // cursor line base addresses
    localparam logic [7:0] LINE0_BASE = 8'h80;
    localparam logic [7:0] LINE1_BASE = 8'hC0;

    // step counts and hold times
    localparam int         STEP_W      = 5;
    localparam int         HOLD_W      = 15;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd24;
    localparam logic [HOLD_W-1:0] HOLD_STROBE    = 15'd1;
    localparam logic [HOLD_W-1:0] HOLD_NIBBLE    = 15'd50;
    localparam logic [HOLD_W-1:0] HOLD_BYTE      = 15'd100;

    // one queued job: a byte to send or the power-up sequence
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
    } t_job;

    // one pin step on the result side
    typedef struct packed {
        logic              rs;
        logic              en;
        logic [3:0]        nib;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_step;

    // one entry of the power-up sequence
    typedef struct packed {
        logic              en;
        logic [3:0]        nib;
        logic [HOLD_W-1:0] hold;
    } t_init_ent;

    // power-up sequence; entry 0 keeps the data pins, its nibble is unused
    function automatic t_init_ent init_step(input logic [STEP_W-1:0] idx);
        t_init_ent e;
        e = '{en: 1'b0, nib: 4'h0, hold: HOLD_STROBE};
        unique case (idx)
            5'd0:  e = '{en: 1'b0, nib: 4'h0, hold: 15'd20000};
            5'd1:  e = '{en: 1'b1, nib: 4'h3, hold: HOLD_STROBE};
            5'd2:  e = '{en: 1'b0, nib: 4'h3, hold: 15'd5050};
            5'd3:  e = '{en: 1'b1, nib: 4'h3, hold: HOLD_STROBE};
            5'd4:  e = '{en: 1'b0, nib: 4'h3, hold: 15'd250};
            5'd5:  e = '{en: 1'b1, nib: 4'h3, hold: HOLD_STROBE};
            5'd6:  e = '{en: 1'b0, nib: 4'h3, hold: 15'd250};
            5'd7:  e = '{en: 1'b1, nib: 4'h2, hold: HOLD_STROBE};
            5'd8:  e = '{en: 1'b0, nib: 4'h2, hold: 15'd250};
            // function set 0x28
            5'd9:  e = '{en: 1'b1, nib: 4'h2, hold: HOLD_STROBE};
            5'd10: e = '{en: 1'b0, nib: 4'h2, hold: HOLD_NIBBLE};
            5'd11: e = '{en: 1'b1, nib: 4'h8, hold: HOLD_STROBE};
            5'd12: e = '{en: 1'b0, nib: 4'h8, hold: HOLD_BYTE};
            // display on 0x0C
            5'd13: e = '{en: 1'b1, nib: 4'h0, hold: HOLD_STROBE};
            5'd14: e = '{en: 1'b0, nib: 4'h0, hold: HOLD_NIBBLE};
            5'd15: e = '{en: 1'b1, nib: 4'hC, hold: HOLD_STROBE};
            5'd16: e = '{en: 1'b0, nib: 4'hC, hold: HOLD_BYTE};
            // entry mode 0x06
            5'd17: e = '{en: 1'b1, nib: 4'h0, hold: HOLD_STROBE};
            5'd18: e = '{en: 1'b0, nib: 4'h0, hold: HOLD_NIBBLE};
            5'd19: e = '{en: 1'b1, nib: 4'h6, hold: HOLD_STROBE};
            5'd20: e = '{en: 1'b0, nib: 4'h6, hold: HOLD_BYTE};
            // clear 0x01, with the clear delay
            5'd21: e = '{en: 1'b1, nib: 4'h0, hold: HOLD_STROBE};
            5'd22: e = '{en: 1'b0, nib: 4'h0, hold: HOLD_NIBBLE};
            5'd23: e = '{en: 1'b1, nib: 4'h1, hold: HOLD_STROBE};
            5'd24: e = '{en: 1'b0, nib: 4'h1, hold: 15'd2100};
            default: e = '{en: 1'b0, nib: 4'h0, hold: HOLD_STROBE};
        endcase
        return e;
    endfunction

endpackage

[design/lcdn_front.sv]
module lcdn_front
    import lcdn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_value,
    input  logic       i_row,
    input  logic [5:0] i_col,
    output logic       o_full,
    output t_job       o_job,
    output logic       o_job_valid,
    input  logic       i_job_take
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_job       n_job;
    logic [7:0] cursor_addr;
    logic       do_push;
    logic       do_pop;

    // cursor address from line base and column
    assign cursor_addr = (i_row ? LINE1_BASE : LINE0_BASE) + {2'b00, i_col};

    // classify the request into a job word
    always_comb begin
        n_job = '{is_init: 1'b0, rs: 1'b0, byte_val: i_value};
        unique case (i_req_type)
            REQ_CHAR:   n_job = '{is_init: 1'b0, rs: 1'b1, byte_val: i_value};
            REQ_CMD:    n_job = '{is_init: 1'b0, rs: 1'b0, byte_val: i_value};
            REQ_CURSOR: n_job = '{is_init: 1'b0, rs: 1'b0, byte_val: cursor_addr};
            REQ_INIT:   n_job = '{is_init: 1'b1, rs: 1'b0, byte_val: 8'h00};
            default:    n_job = '{is_init: 1'b0, rs: 1'b0, byte_val: i_value};
        endcase
    end

    // two-entry job queue
    assign o_full      = r_count[1];
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[design/lcdn_back.sv]
module lcdn_back
    import lcdn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  logic              i_job_valid,
    output logic              o_job_take,
    output logic              o_empty,
    input  logic              i_pop,
    output logic              o_rs,
    output logic              o_en,
    output logic [3:0]        o_data_nibble,
    output logic [HOLD_W-1:0] o_hold_us,
    output logic              o_last
);

    t_job              r_job;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [3:0]        r_data_pins;
    t_step             r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    t_step             n_step;
    t_init_ent         init_ent;
    logic              emit;
    logic              do_pop;
    logic              load;

    // decode the current pin step
    assign init_ent = init_step(r_step);

    always_comb begin
        if (r_job.is_init) begin
            n_step.rs   = 1'b0;
            n_step.en   = init_ent.en;
            n_step.nib  = (r_step == '0) ? r_data_pins : init_ent.nib;
            n_step.hold = init_ent.hold;
            n_step.last = (r_step == INIT_LAST_STEP);
        end else begin
            n_step.rs   = r_job.rs;
            n_step.en   = ~r_step[0];
            n_step.nib  = r_step[1] ? r_job.byte_val[3:0] : r_job.byte_val[7:4];
            n_step.hold = r_step[0] ? (r_step[1] ? HOLD_BYTE : HOLD_NIBBLE) : HOLD_STROBE;
            n_step.last = (r_step == BYTE_LAST_STEP);
        end
    end

    // sequencer: one step a cycle while the result queue has room
    assign emit       = r_busy && !r_count[1];
    assign load       = (!r_busy || (emit && n_step.last)) && i_job_valid;
    assign o_job_take = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_data_pins <= 4'h0;
        end else begin
            if (emit) begin
                r_data_pins <= n_step.nib;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (emit) begin
                if (n_step.last) begin
                    r_busy <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end
        end
    end

    // two-entry result queue
    assign o_empty       = (r_count == 2'd0);
    assign do_pop        = i_pop && !o_empty;
    assign o_rs          = r_mem[r_rd_ptr].rs;
    assign o_en          = r_mem[r_rd_ptr].en;
    assign o_data_nibble = r_mem[r_rd_ptr].nib;
    assign o_hold_us     = r_mem[r_rd_ptr].hold;
    assign o_last        = r_mem[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_mem[r_wr_ptr] <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (emit) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (emit && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!emit && do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[design/char_lcd_nibble_interface_top.sv]
// Character LCD driver for a 4-bit bus. Each request (write character, write
// command byte, set cursor, power-up sequence) becomes a run of pin-step words
// (rs, en, data nibble, hold time in us, last flag) that the caller plays out on
// the pins. A byte request gives 4 steps and the power-up sequence gives 25.
// The step sequencer emits one pin step per clock while the result queue has
// room; requests queue two deep in front of it and steps queue two deep
// behind it, so requests may arrive back to back and a stalled reader only
// stops the sequencer once the result queue is full. A request passes through
// the job queue and the sequencer's job register before its first step is
// written to the result queue.
module char_lcd_nibble_interface_top
    import lcdn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_value,
    input  logic              i_row,
    input  logic [5:0]        i_col,
    output logic              empty,
    input  logic              pop,
    output logic              o_rs,
    output logic              o_en,
    output logic [3:0]        o_data_nibble,
    output logic [HOLD_W-1:0] o_hold_us,
    output logic              o_last
);

    t_job job;
    logic job_valid;
    logic job_take;

    // request classifier and job queue
    lcdn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_full      (full),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_take  (job_take)
    );

    // pin-step sequencer and result queue
    lcdn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job),
        .i_job_valid   (job_valid),
        .o_job_take    (job_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_rs          (o_rs),
        .o_en          (o_en),
        .o_data_nibble (o_data_nibble),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule

[bench/char_lcd_nibble_interface_top_test.sv]
`timescale 1ns / 1ps

module char_lcd_nibble_interface_top_test
    import lcdn_pkg::*;
;

    // clock, reset and block inputs, all known from time zero
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              push          = 1'b0;
    logic [1:0]        i_req_type    = REQ_CHAR;
    logic [7:0]        i_value       = 8'h00;
    logic              i_row         = 1'b0;
    logic [5:0]        i_col         = 6'd0;
    logic              pop           = 1'b0;
    logic              full;
    logic              empty;
    logic              o_rs;
    logic              o_en;
    logic [3:0]        o_data_nibble;
    logic [HOLD_W-1:0] o_hold_us;
    logic              o_last;

    // predicted pin steps, oldest first, and the predicted level of D7..D4
    t_step             pending_steps[$];
    logic [3:0]        pin_level;

    // traffic shaping
    bit                steady     = 1'b0;
    bit                rx_blocked = 1'b0;

    int                error_count   = 0;
    int                request_count = 0;
    int                init_count    = 0;
    int                step_count    = 0;

    char_lcd_nibble_interface_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_row         (i_row),
        .i_col         (i_col),
        .empty         (empty),
        .pop           (pop),
        .o_rs          (o_rs),
        .o_en          (o_en),
        .o_data_nibble (o_data_nibble),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // pin step predictor
    task automatic queue_pin_step(input logic rs, input logic en, input logic [3:0] nib,
                                  input int hold);
        t_step s;
        s.rs   = rs;
        s.en   = en;
        s.nib  = nib;
        s.hold = hold[HOLD_W-1:0];
        s.last = 1'b0;
        pending_steps.push_back(s);
        pin_level = nib;
    endtask

    // strobe high for 1 us, then low for 50 us plus any trailing delay
    task automatic queue_nibble(input logic rs, input logic [3:0] nib, input int extra);
        queue_pin_step(rs, 1'b1, nib, 1);
        queue_pin_step(rs, 1'b0, nib, 50 + extra);
    endtask

    // high nibble then low nibble; the byte delay lands on the final step
    task automatic queue_byte(input logic rs, input logic [7:0] b, input int extra);
        queue_nibble(rs, b[7:4], 0);
        queue_nibble(rs, b[3:0], 50 + extra);
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [7:0] val,
                                   input logic row, input logic [5:0] col);
        t_step      tail;
        logic [7:0] addr;
        case (kind)
            REQ_CHAR: queue_byte(1'b1, val, 0);
            REQ_CMD:  queue_byte(1'b0, val, 0);
            REQ_CURSOR: begin
                addr = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, col};
                queue_byte(1'b0, addr, 0);
            end
            default: begin
                // power-up wait keeps whatever the data lines already show
                queue_pin_step(1'b0, 1'b0, pin_level, 20000);
                queue_nibble(1'b0, 4'h3, 5000);
                queue_nibble(1'b0, 4'h3, 200);
                queue_nibble(1'b0, 4'h3, 200);
                queue_nibble(1'b0, 4'h2, 200);
                queue_byte(1'b0, 8'h28, 0);
                queue_byte(1'b0, 8'h0C, 0);
                queue_byte(1'b0, 8'h06, 0);
                queue_byte(1'b0, 8'h01, 2000);
            end
        endcase
        tail = pending_steps.pop_back();
        tail.last = 1'b1;
        pending_steps.push_back(tail);
    endtask

    // send one request word; entered and left at a falling edge
    task automatic send_request(input logic [1:0] kind, input logic [7:0] val,
                                input logic row, input logic [5:0] col);
        while (!steady && $urandom_range(99) < 20) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= kind;
        i_value    <= val;
        i_row      <= row;
        i_col      <= col;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_request(kind, val, row, col);
        request_count++;
        if (kind == REQ_INIT) init_count++;
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(99);
        if (pick < 35)      kind = REQ_CHAR;
        else if (pick < 65) kind = REQ_CMD;
        else if (pick < 93) kind = REQ_CURSOR;
        else                kind = REQ_INIT;
        send_request(kind, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     6'($urandom_range(63)));
    endtask

    // stop sending until every predicted step has been read back
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_steps.size() != 0) @(negedge i_clk);
    endtask

    // result reader: pop ready most of the time
    always @(negedge i_clk) begin
        if (rx_blocked)  pop <= 1'b0;
        else if (steady) pop <= 1'b1;
        else             pop <= ($urandom_range(99) >= 20);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // compare each popped word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_step want;
        if (i_rst_n && pop && !empty) begin
            if (pending_steps.size() == 0) begin
                $display({"%0t: unexpected pin step, expected none, ",
                          "got rs=%0b en=%0b nib=%h hold=%0d last=%0b"},
                         $time, o_rs, o_en, o_data_nibble, o_hold_us, o_last);
                error_count++;
            end else begin
                want = pending_steps.pop_front();
                check_field("rs", want.rs, o_rs);
                check_field("en", want.en, o_en);
                check_field("data_nibble", want.nib, o_data_nibble);
                check_field("hold_us", want.hold, o_hold_us);
                check_field("last", want.last, o_last);
                step_count++;
            end
        end
    end

    // characters and commands at the edges of the byte range, junk in unused fields
    task automatic test_write_extremes();
        send_request(REQ_CHAR, 8'h00, 1'b0, 6'd0);
        send_request(REQ_CHAR, 8'hFF, 1'b1, 6'd63);
        send_request(REQ_CHAR, 8'hA5, 1'b1, 6'h2A);
        send_request(REQ_CMD,  8'h00, 1'b1, 6'h15);
        send_request(REQ_CMD,  8'hFF, 1'b0, 6'd63);
        send_request(REQ_CMD,  8'h5A, 1'b0, 6'd0);
    endtask

    // both lines, first and last column, value ignored
    task automatic test_cursor_corners();
        send_request(REQ_CURSOR, 8'hFF, 1'b0, 6'd0);
        send_request(REQ_CURSOR, 8'h00, 1'b1, 6'd63);
        send_request(REQ_CURSOR, 8'h3C, 1'b0, 6'd63);
        send_request(REQ_CURSOR, 8'hC3, 1'b1, 6'd0);
    endtask

    // power-up wait step after different last nibbles on the data lines
    task automatic test_power_up();
        send_request(REQ_INIT, 8'hFF, 1'b1, 6'd63);
        send_request(REQ_CHAR, 8'hF7, 1'b0, 6'd0);
        send_request(REQ_INIT, 8'h00, 1'b0, 6'd0);
        send_request(REQ_INIT, 8'h5A, 1'b1, 6'h2A);
        send_request(REQ_CMD,  8'h3C, 1'b0, 6'd0);
        send_request(REQ_INIT, 8'hA5, 1'b0, 6'h15);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_request();
    endtask

    // no idling on either side
    task automatic test_steady_traffic(input int count);
        steady = 1'b1;
        repeat (count) send_random_request();
        steady = 1'b0;
    endtask

    // reader stalled while requests pile up against a full block, then released
    task automatic test_reader_stall();
        rx_blocked = 1'b1;
        fork
            repeat (8) send_random_request();
            begin
                repeat (30) @(negedge i_clk);
                rx_blocked = 1'b0;
            end
        join
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        pin_level = 4'h0;
        @(negedge i_clk);

        test_write_extremes();
        test_cursor_corners();
        test_power_up();
        test_random_traffic(150);
        wait_drained();
        test_steady_traffic(100);
        test_reader_stall();
        test_random_traffic(150);

        // let the tail drain, then allow for the pipeline latency
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (pending_steps.size() != 0) begin
            $display("%0t: %0d pin steps expected, got none", $time, pending_steps.size());
            error_count++;
        end

        $display("%0d requests sent, %0d of them power-up sequences", request_count, init_count);
        $display("%0d pin steps checked, %0d mismatches", step_count, error_count);
        if (error_count == 0) begin
            $display("[char_lcd_nibble_interface_top] OK");
        end else begin
            $display("[char_lcd_nibble_interface_top] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("[char_lcd_nibble_interface_top] ERROR");
        $finish;
    end

endmodule
